// ===== hdl/bcdrtc_pkg.sv =====
// ---------------------------------------------------------------------------
// bcdrtc_pkg
// Shared types, register map and constants of the BCD real-time clock.
// ---------------------------------------------------------------------------
package bcdrtc_pkg;

  // default timing: 64 Hz period in half microseconds, divide-by-64 to 1 Hz
  localparam int PERIOD_HALFUS_DEF = 31250;
  localparam int PRESCALE_DEF      = 64;

  localparam int ELAPSED_W = 16;
  localparam int DATA_W    = 8;
  localparam int ADDR_W    = 4;
  localparam int DIGIT_W   = 4;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // register map
  localparam logic [ADDR_W-1:0] REG_SEC_UNITS = 4'h0;
  localparam logic [ADDR_W-1:0] REG_SEC_TENS  = 4'h1;
  localparam logic [ADDR_W-1:0] REG_MIN_UNITS = 4'h2;
  localparam logic [ADDR_W-1:0] REG_MIN_TENS  = 4'h3;
  localparam logic [ADDR_W-1:0] REG_HR_UNITS  = 4'h4;
  localparam logic [ADDR_W-1:0] REG_HR_TENS   = 4'h5;
  localparam logic [ADDR_W-1:0] REG_CTRL_D    = 4'hD;
  localparam logic [ADDR_W-1:0] REG_CTRL_E    = 4'hE;
  localparam logic [ADDR_W-1:0] REG_CTRL_F    = 4'hF;

  // control register bits
  localparam logic [DATA_W-1:0] CE_MASK_MASK = 8'h01;
  localparam logic [DATA_W-1:0] CE_STND_MASK = 8'h02;
  localparam logic [DATA_W-1:0] CF_REST_MASK = 8'h01;
  localparam logic [DATA_W-1:0] CD_IRQ_MASK  = 8'h04;
  localparam logic [DATA_W-1:0] CE_RESET     = CE_MASK_MASK;

  // last value of a decimal digit and of a tens-of-sixty digit
  localparam logic [3:0] DEC_LAST  = 4'd9;
  localparam logic [2:0] SEXA_LAST = 3'd5;

  typedef struct packed {
    logic [1:0]           command;
    logic [ADDR_W-1:0]    address;
    logic [DATA_W-1:0]    write_data;
    logic [ELAPSED_W-1:0] elapsed_halfus;
  } req_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] read_data;
    logic               irq_level;
  } rsp_t;

  // control from the register logic to the timekeeper
  typedef struct packed {
    logic                 tick;
    logic                 hold;
    logic                 clear;
    logic [ELAPSED_W-1:0] elapsed;
  } tk_ctrl_t;

  // timekeeper status: period events and the digit registers
  typedef struct packed {
    logic       half_hit;
    logic       period_hit;
    logic [3:0] sec_units;
    logic [2:0] sec_tens;
    logic [3:0] min_units;
    logic [2:0] min_tens;
    logic [3:0] hr_units;
    logic [1:0] hr_tens;
  } tk_status_t;

endpackage

// ===== hdl/bcdrtc_timekeeper.sv =====
// ---------------------------------------------------------------------------
// bcdrtc_timekeeper
// Half-microsecond accumulator, prescaler and BCD time-of-day counters.
// ---------------------------------------------------------------------------
module bcdrtc_timekeeper #(
  parameter int PERIOD_HALFUS = bcdrtc_pkg::PERIOD_HALFUS_DEF,
  parameter int PRESCALE      = bcdrtc_pkg::PRESCALE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bcdrtc_pkg::tk_ctrl_t   ctrl,
  output bcdrtc_pkg::tk_status_t status
);
  import bcdrtc_pkg::*;

  // accumulator always stays below the period between ticks
  localparam int ACC_W = $clog2(PERIOD_HALFUS);
  localparam int SUM_W = $clog2(PERIOD_HALFUS + (1 << ELAPSED_W));
  localparam int HALF  = PERIOD_HALFUS / 2;
  localparam int PS_W  = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;

  logic [ACC_W-1:0] acc;
  logic [PS_W-1:0]  prescaler;
  logic [3:0]       sec_units;
  logic [2:0]       sec_tens;
  logic [3:0]       min_units;
  logic [2:0]       min_tens;
  logic [3:0]       hr_units;
  logic [1:0]       hr_tens;

  logic [SUM_W-1:0] sum;
  logic             half_hit;
  logic             period_hit;
  logic [PS_W:0]    ps_inc;
  logic             ps_wrap;
  logic             step_sec;
  logic             c_su, c_st, c_mu, c_mt;
  logic             hr_roll;

  // accumulate, held at zero while the reset bit is set
  always_comb begin
    sum        = ctrl.hold ? '0 : SUM_W'(acc) + SUM_W'(ctrl.elapsed);
    half_hit   = sum >= SUM_W'(HALF);
    period_hit = sum >= SUM_W'(PERIOD_HALFUS);
  end

  // prescaler and digit carry chain
  always_comb begin
    ps_inc   = {1'b0, prescaler} + (PS_W+1)'(1);
    ps_wrap  = ps_inc >= (PS_W+1)'(PRESCALE);
    step_sec = ctrl.tick && period_hit && ps_wrap;
    c_su     = step_sec && (sec_units >= DEC_LAST);
    c_st     = c_su && (sec_tens >= SEXA_LAST);
    c_mu     = c_st && (min_units >= DEC_LAST);
    c_mt     = c_mu && (min_tens >= SEXA_LAST);
    hr_roll  = (hr_tens >= 2'd2) && (hr_units >= 4'd3);
  end

  // accumulator and prescaler
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      prescaler <= '0;
    end else begin
      if (ctrl.clear) begin
        acc <= '0;
      end else if (ctrl.tick) begin
        acc <= period_hit ? '0 : sum[ACC_W-1:0];
      end
      if (ctrl.tick && period_hit) begin
        prescaler <= ps_wrap ? '0 : ps_inc[PS_W-1:0];
      end
    end
  end

  // seconds and minutes
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_units <= '0;
      sec_tens  <= '0;
      min_units <= '0;
      min_tens  <= '0;
    end else begin
      if (step_sec) begin
        sec_units <= c_su ? 4'd0 : sec_units + 4'd1;
      end
      if (c_su) begin
        sec_tens <= c_st ? 3'd0 : sec_tens + 3'd1;
      end
      if (c_st) begin
        min_units <= c_mu ? 4'd0 : min_units + 4'd1;
      end
      if (c_mu) begin
        min_tens <= c_mt ? 3'd0 : min_tens + 3'd1;
      end
    end
  end

  // hours, 23 rolls over to 00
  always_ff @(posedge clk) begin
    if (rst) begin
      hr_units <= '0;
      hr_tens  <= '0;
    end else if (c_mt) begin
      if (hr_roll) begin
        hr_units <= 4'd0;
        hr_tens  <= 2'd0;
      end else if (hr_units >= DEC_LAST) begin
        hr_units <= 4'd0;
        hr_tens  <= (hr_tens >= 2'd2) ? 2'd0 : hr_tens + 2'd1;
      end else begin
        hr_units <= hr_units + 4'd1;
      end
    end
  end

  always_comb begin
    status.half_hit   = half_hit;
    status.period_hit = period_hit;
    status.sec_units  = sec_units;
    status.sec_tens   = sec_tens;
    status.min_units  = min_units;
    status.min_tens   = min_tens;
    status.hr_units   = hr_units;
    status.hr_tens    = hr_tens;
  end

endmodule

// ===== hdl/bcd_real_time_clock_with_irq_core.sv =====
// ---------------------------------------------------------------------------
// bcd_real_time_clock_with_irq_core
// BCD real-time clock with a level interrupt, driven by tick and bus items.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid, req_stall, req): one item per transfer, a time
//   tick carrying elapsed half microseconds, a register read or a register
//   write. rsp channel (rsp_valid, rsp_stall, rsp): exactly one result per
//   item, in order, with the read digit (zero for non-reads) and the
//   interrupt level after the item.
//   Path: each item passes the input register, then the result register.
//   Throughput: one item per cycle while rsp_stall does not hold a valid
//   result; the whole update (accumulator add and compare, prescaler, BCD
//   carry chain, register decode) is one pass between the two registers.
//   Stalls: while rsp_stall holds a valid result, the input register keeps
//   its item and req_stall rises only if that register is occupied, so one
//   item can still be taken during a stall.
//   Reset: time, prescaler and accumulator clear, the interrupt is low,
//   control E has its mask bit set and control F is zero. Both channels
//   come out of reset empty.
// ---------------------------------------------------------------------------
module bcd_real_time_clock_with_irq_core #(
  parameter int PERIOD_HALFUS = bcdrtc_pkg::PERIOD_HALFUS_DEF,
  parameter int PRESCALE      = bcdrtc_pkg::PRESCALE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  bcdrtc_pkg::req_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output bcdrtc_pkg::rsp_t  rsp
);
  import bcdrtc_pkg::*;

  logic        stg_valid;
  req_t        stg;
  logic        advance;
  logic        fire;
  logic        is_tick, is_read, is_write;

  logic [DATA_W-1:0] control_e;
  logic [DATA_W-1:0] control_f;
  logic              irq_pending;
  logic              irq_pending_next;
  logic [DIGIT_W-1:0] rd_digit;
  rsp_t              rsp_next;

  tk_ctrl_t   tk_ctrl;
  tk_status_t tk_status;

  // handshake: the result register frees when empty or taken
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = stg_valid && !advance;
  assign fire      = stg_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (!req_stall) begin
      stg_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      stg <= req;
    end
  end

  // command decode
  assign is_tick  = stg.command == CMD_TICK;
  assign is_read  = stg.command == CMD_READ;
  assign is_write = stg.command == CMD_WRITE;

  // timekeeper control
  always_comb begin
    tk_ctrl.tick    = fire && is_tick;
    tk_ctrl.hold    = (control_f & CF_REST_MASK) != '0;
    tk_ctrl.clear   = fire && is_write && (stg.address == REG_CTRL_F) &&
                      ((stg.write_data & CF_REST_MASK) != '0);
    tk_ctrl.elapsed = stg.elapsed_halfus;
  end

  bcdrtc_timekeeper #(
    .PERIOD_HALFUS (PERIOD_HALFUS),
    .PRESCALE      (PRESCALE)
  ) u_timekeeper (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (tk_ctrl),
    .status (tk_status)
  );

  // interrupt level update
  always_comb begin
    irq_pending_next = irq_pending;
    if (is_tick) begin
      if (tk_status.half_hit && ((control_e & CE_STND_MASK) == '0)) begin
        irq_pending_next = 1'b0;
      end
      if (tk_status.period_hit && ((control_e & ~CE_STND_MASK) == '0)) begin
        irq_pending_next = 1'b1;
      end
    end else if (is_write && (stg.address == REG_CTRL_D) &&
                 ((stg.write_data & CD_IRQ_MASK) == '0)) begin
      irq_pending_next = 1'b0;
    end
  end

  // digit register read
  always_comb begin
    case (stg.address)
      REG_SEC_UNITS: rd_digit = tk_status.sec_units;
      REG_SEC_TENS:  rd_digit = DIGIT_W'(tk_status.sec_tens);
      REG_MIN_UNITS: rd_digit = tk_status.min_units;
      REG_MIN_TENS:  rd_digit = DIGIT_W'(tk_status.min_tens);
      REG_HR_UNITS:  rd_digit = tk_status.hr_units;
      REG_HR_TENS:   rd_digit = DIGIT_W'(tk_status.hr_tens);
      default:       rd_digit = '0;
    endcase
  end

  always_comb begin
    rsp_next.read_data = is_read ? rd_digit : '0;
    rsp_next.irq_level = irq_pending_next;
  end

  // control registers and interrupt
  always_ff @(posedge clk) begin
    if (rst) begin
      control_e   <= CE_RESET;
      control_f   <= '0;
      irq_pending <= 1'b0;
    end else if (fire) begin
      irq_pending <= irq_pending_next;
      if (is_write && (stg.address == REG_CTRL_E)) begin
        control_e <= stg.write_data;
      end
      if (is_write && (stg.address == REG_CTRL_F)) begin
        control_f <= stg.write_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  // the shown level always tracks the interrupt state
  a_irq_tracks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.irq_level == irq_pending))
    else $error("result interrupt level differs from interrupt state");

  // a control D write with the flag clear lowers the interrupt
  a_irq_ack: assert property (@(posedge clk) disable iff (rst)
    (fire && is_write && (stg.address == REG_CTRL_D) &&
     ((stg.write_data & CD_IRQ_MASK) == '0)) |=> !irq_pending)
    else $error("interrupt not lowered by control D write");

  // time digits stay in legal BCD ranges
  a_digits_legal: assert property (@(posedge clk) disable iff (rst)
    (tk_status.sec_units <= DEC_LAST) && (tk_status.sec_tens <= SEXA_LAST) &&
    (tk_status.min_units <= DEC_LAST) && (tk_status.min_tens <= SEXA_LAST) &&
    (tk_status.hr_units <= DEC_LAST) &&
    ((tk_status.hr_tens < 2'd2) || (tk_status.hr_units <= 4'd3)))
    else $error("time digits out of range");

endmodule
